// ===== rtl/core/rit_pkg.sv =====
// Package of shared types and constants for the reference-counted inode table.
`timescale 1ns / 1ps
package rit_pkg;

    typedef enum logic [1:0] {
        KIND_GET  = 2'd0,
        KIND_PUT  = 2'd1,
        KIND_MARK = 2'd2,
        KIND_SYNC = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_BUSY = 2'd2
    } status_t;

    localparam int unsigned DEV_W   = 16;
    localparam int unsigned NUM_W   = 32;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned SLOT_W  = 5;
    localparam int unsigned RESULT_LIMIT = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        kind_t              kind;
        logic [DEV_W-1:0]   device;
        logic [NUM_W-1:0]   object_number;
        logic [SLOT_W-1:0]  slot;
        logic               is_file_or_dir;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_out;
        logic               hit;
        status_t            status;
        logic               writeback;
        logic [DEV_W-1:0]   wb_device;
        logic [NUM_W-1:0]   wb_number;
        logic               last;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_FREE,
        ST_SYNC,
        ST_EMIT
    } exec_state_t;

endpackage

// ===== rtl/core/rit_front.sv =====
// Front end: accepts request words and queues them for the execution engine.
`timescale 1ns / 1ps
module rit_front
    import rit_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t req_in,
    output logic req_valid,
    input  logic req_take,
    output req_t req_out
);

    req_t       q_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full      = (cnt_reg == 2'd2);
    assign req_valid = (cnt_reg != 2'd0);
    assign req_out   = q_reg[rp_reg];
    assign do_push   = push && !full;
    assign do_pop    = req_take && req_valid;

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= req_in;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !do_pop) else $error("pop from empty queue");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        full && !req_take |=> full) else $error("full queue lost a word");
`endif

endmodule

// ===== rtl/core/rit_exec.sv =====
// Execution engine: holds the table and carries out get, put, mark and sync.
`timescale 1ns / 1ps
module rit_exec
    import rit_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_take,
    input  req_t req,
    output logic res_valid,
    input  logic res_take,
    output res_t res
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned PTR_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(TABLE_ENTRIES - 1);

    logic [DEV_W-1:0] dev_reg   [TABLE_ENTRIES];
    logic [NUM_W-1:0] num_reg   [TABLE_ENTRIES];
    logic [CNT_W-1:0] cnt_reg   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] dirty_reg, fod_reg;

    exec_state_t state_reg, state_next;
    req_t        cur_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic        any_reg, any_next;
    logic [SLOT_W:0] emits_reg, emits_next;
    res_t        res_reg, res_next;
    logic        res_valid_reg, res_valid_next;

    logic [IDX_W-1:0] ci;
    logic        match, freeent, qual, is_last_idx, slot_ok;
    logic [IDX_W-1:0] sidx;
    logic        squal;
    logic        limit_hit;
    logic [TABLE_ENTRIES-1:0] nz_vec, upper_vec, pending_vec;

    assign ci          = idx_reg;
    assign match       = (dev_reg[ci] == cur_reg.device)
                         && (num_reg[ci] == cur_reg.object_number);
    assign freeent     = (cnt_reg[ci] == '0);
    assign qual        = dirty_reg[ci] && fod_reg[ci] && (dev_reg[ci] != '0);
    assign is_last_idx = ({1'b0, ci} == LAST_IDX);
    assign slot_ok     = (32'(req.slot) < TABLE_ENTRIES);
    assign sidx        = IDX_W'(req.slot);
    assign squal       = dirty_reg[sidx] && fod_reg[sidx] && (dev_reg[sidx] != '0);
    assign limit_hit   = (emits_reg == (SLOT_W+1)'(RESULT_LIMIT - 1));

    // Entries above the current one that still wait for write-back.
    always_comb
    begin
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            nz_vec[k]    = (dev_reg[k] != '0);
            upper_vec[k] = (k > int'(ci));
        end
    end

    assign pending_vec = dirty_reg & fod_reg & nz_vec & upper_vec;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && !res_valid_reg)
                begin
                    if (req.kind == KIND_GET)
                        state_next = ST_MATCH;
                    else if (req.kind == KIND_SYNC)
                        state_next = ST_SYNC;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_MATCH:
            begin
                if (match)
                    state_next = ST_IDLE;
                else if (is_last_idx)
                    state_next = ST_FREE;
            end
            ST_FREE:
            begin
                if (freeent || is_last_idx)
                    state_next = ST_IDLE;
            end
            ST_SYNC:
            begin
                if (qual)
                    state_next = ST_EMIT;
                else if (is_last_idx)
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!res_valid_reg)
                    state_next = (is_last_idx || limit_hit) ? ST_IDLE : ST_SYNC;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        req_take       = 1'b0;
        idx_next       = idx_reg;
        any_next       = any_reg;
        emits_next     = emits_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_take;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && !res_valid_reg)
                begin
                    req_take   = 1'b1;
                    idx_next   = '0;
                    any_next   = 1'b0;
                    emits_next = '0;
                    res_next   = '0;
                    res_next.last = 1'b1;
                    if (req.kind == KIND_PUT || req.kind == KIND_MARK)
                    begin
                        res_valid_next    = 1'b1;
                        res_next.slot_out = req.slot;
                        if (slot_ok && req.kind == KIND_PUT)
                        begin
                            if (squal)
                            begin
                                res_next.writeback = 1'b1;
                                res_next.wb_device = dev_reg[sidx];
                                res_next.wb_number = num_reg[sidx];
                            end
                            if (cnt_reg[sidx] > CNT_W'(1))
                                res_next.status = STATUS_BUSY;
                        end
                    end
                end
            end
            ST_MATCH:
            begin
                if (match)
                begin
                    res_valid_next    = 1'b1;
                    res_next          = '0;
                    res_next.slot_out = SLOT_W'(ci);
                    res_next.hit      = 1'b1;
                    res_next.last     = 1'b1;
                end
                else
                    idx_next = is_last_idx ? '0 : idx_reg + 1'b1;
            end
            ST_FREE:
            begin
                if (freeent || is_last_idx)
                begin
                    res_valid_next    = 1'b1;
                    res_next          = '0;
                    res_next.last     = 1'b1;
                    if (freeent)
                        res_next.slot_out = SLOT_W'(ci);
                    else
                        res_next.status = STATUS_FULL;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_SYNC:
            begin
                if (!qual)
                begin
                    if (is_last_idx)
                    begin
                        if (!any_reg)
                        begin
                            res_valid_next = 1'b1;
                            res_next       = '0;
                            res_next.last  = 1'b1;
                        end
                    end
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!res_valid_reg)
                begin
                    res_valid_next     = 1'b1;
                    any_next           = 1'b1;
                    emits_next         = emits_reg + 1'b1;
                    res_next           = '0;
                    res_next.slot_out  = SLOT_W'(ci);
                    res_next.writeback = 1'b1;
                    res_next.wb_device = dev_reg[ci];
                    res_next.wb_number = num_reg[ci];
                    res_next.last      = is_last_idx || limit_hit || (pending_vec == '0);
                    if (!is_last_idx)
                        idx_next = idx_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            idx_reg       <= '0;
            any_reg       <= 1'b0;
            emits_reg     <= '0;
            dirty_reg     <= '0;
            fod_reg       <= '0;
            for (int k = 0; k < TABLE_ENTRIES; k++)
            begin
                dev_reg[k] <= '0;
                num_reg[k] <= '0;
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            idx_reg       <= idx_next;
            any_reg       <= any_next;
            emits_reg     <= emits_next;
            if (state_reg == ST_IDLE && req_take && slot_ok)
            begin
                if (req.kind == KIND_MARK)
                begin
                    dirty_reg[sidx] <= 1'b1;
                    fod_reg[sidx]   <= req.is_file_or_dir;
                end
                else if (req.kind == KIND_PUT)
                begin
                    if (cnt_reg[sidx] > CNT_W'(1))
                    begin
                        cnt_reg[sidx]   <= cnt_reg[sidx] - 1'b1;
                        if (squal)
                            dirty_reg[sidx] <= 1'b0;
                    end
                    else
                    begin
                        dev_reg[sidx]   <= '0;
                        num_reg[sidx]   <= '0;
                        cnt_reg[sidx]   <= '0;
                        dirty_reg[sidx] <= 1'b0;
                        fod_reg[sidx]   <= 1'b0;
                    end
                end
            end
            if (state_reg == ST_MATCH && match && cnt_reg[ci] != CNT_MAX)
                cnt_reg[ci] <= cnt_reg[ci] + 1'b1;
            if (state_reg == ST_FREE && freeent)
            begin
                dev_reg[ci] <= cur_reg.device;
                num_reg[ci] <= cur_reg.object_number;
                cnt_reg[ci] <= CNT_W'(1);
                fod_reg[ci] <= 1'b0;
            end
            if (state_reg == ST_EMIT && !res_valid_reg)
                dirty_reg[ci] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            cur_reg <= req;
        res_reg <= res_next;
    end

`ifndef NO_ASSERTIONS
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |-> state_reg == ST_IDLE) else $error("request taken while busy");
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_take |=> res_valid_reg && $stable(res_reg))
        else $error("result changed while waiting");
    a_emit_qual: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SYNC && qual |=> state_reg == ST_EMIT)
        else $error("qualifying entry skipped");
`endif

endmodule

// ===== rtl/core/refcounted_inode_table_core.sv =====
// Top level of the reference-counted inode table.
`timescale 1ns / 1ps
// The block is used as a pair of queues. Request words enter on push while
// full is low; each carries kind, device, object_number, slot and
// is_file_or_dir. Result words leave on pop while empty is low; last marks
// the final result word of a request.
// A two-entry request queue parts the front from the execution engine, and
// a result register parts the engine from the receiver.
// Put and mark give their result in the cycle after the engine takes them.
// A get scans the table one entry a cycle for a match and then for a free
// entry. A sync walks the table one entry a cycle, but it pauses at each
// entry that needs write-back and while a result word waits for the
// receiver. The single table scan port sets this pace.
// Reset clears every entry, both queues and the engine at once.
// When the receiver stalls the result word holds, the engine waits and
// the request queue fills, after which full rises.
module refcounted_inode_table_core
    import rit_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [15:0] device,
    input  logic [31:0] object_number,
    input  logic [4:0]  slot,
    input  logic        is_file_or_dir,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  slot_out,
    output logic        hit,
    output logic [1:0]  status,
    output logic        writeback,
    output logic [15:0] wb_device,
    output logic [31:0] wb_number,
    output logic        last
);

    req_t req_in, req_q;
    res_t res_w;
    logic req_valid, req_take, res_valid;

    always_comb
    begin
        req_in.kind           = kind_t'(kind);
        req_in.device         = device;
        req_in.object_number  = object_number;
        req_in.slot           = slot;
        req_in.is_file_or_dir = is_file_or_dir;
    end

    rit_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_in    (req_in),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req_out   (req_q)
    );

    rit_exec #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_take  (req_take),
        .req       (req_q),
        .res_valid (res_valid),
        .res_take  (pop),
        .res       (res_w)
    );

    assign empty     = !res_valid;
    assign slot_out  = res_w.slot_out;
    assign hit       = res_w.hit;
    assign status    = res_w.status;
    assign writeback = res_w.writeback;
    assign wb_device = res_w.wb_device;
    assign wb_number = res_w.wb_number;
    assign last      = res_w.last;

endmodule
